// File: sv/b64_pkg.sv
// Shared types and constants of the base64 line decoder.
package b64_pkg;

  localparam logic [15:0] MAX_BYTES_RST = 16'd6200;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Result kinds, carried on the tuser bit of the result channel.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Work for one accepted character: up to three decoded bytes and an
  // optional end-of-line report.
  typedef struct packed {
    logic        eol;
    logic [15:0] count;
    logic [2:0]  mask;
    logic [7:0]  b2;
    logic [7:0]  b1;
    logic [7:0]  b0;
  } entry_t;

endpackage

// File: sv/b64_front.sv
// Front part: accepts characters, tracks the quad and builds result entries.
module b64_front import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic [5:0]  held_r [3];
  logic [5:0]  held_nxt [3];
  logic [2:0]  inv_r, inv_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        halted_r, halted_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] max_r;

  logic        accept;
  logic [5:0]  v;
  logic        bad;
  logic        quad_done;
  logic        e0, e1, e2, k0, k1, k2;
  logic [15:0] c1, c2, c3;

  function automatic logic [6:0] map_char(input logic [7:0] c);
    // Returns {invalid, value}.
    if (c >= "A" && c <= "Z")      map_char = {1'b0, 6'(c - 8'd65)};
    else if (c >= "a" && c <= "z") map_char = {1'b0, 6'(c - 8'd97 + 8'd26)};
    else if (c >= "0" && c <= "9") map_char = {1'b0, 6'(c - 8'd48 + 8'd52)};
    else if (c == "+")             map_char = {1'b0, 6'd62};
    else if (c == "/")             map_char = {1'b0, 6'd63};
    else                           map_char = {1'b1, 6'd63};
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign {bad, v}  = map_char(in_tdata);

  always_comb begin
    quad_done = !halted_r && (in_tdata != 8'd0) && (pos_r == 2'd3);
    e0 = quad_done && (inv_r[1:0] == 2'b00);
    e1 = e0 && !inv_r[2];
    e2 = e0 && !bad;
    // The byte limit is applied in order across the three candidates.
    k0 = e0 && (cnt_r < max_r);
    c1 = cnt_r + 16'(k0);
    k1 = e1 && (c1 < max_r);
    c2 = c1 + 16'(k1);
    k2 = e2 && (c2 < max_r);
    c3 = c2 + 16'(k2);

    held_nxt   = held_r;
    inv_nxt    = inv_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    cnt_nxt    = c3;
    if (!halted_r) begin
      if (in_tdata == 8'd0) begin
        halted_nxt = 1'b1;
      end else if (pos_r != 2'd3) begin
        held_nxt[pos_r] = v;
        inv_nxt[pos_r]  = inv_r[pos_r] | bad;
        pos_nxt         = pos_r + 2'd1;
      end else begin
        pos_nxt = 2'd0;
        inv_nxt = 3'b000;
        if (inv_r[1:0] != 2'b00) halted_nxt = 1'b1;
      end
    end

    q_entry.b0    = {held_r[0], held_r[1][5:4]};
    q_entry.b1    = {held_r[1][3:0], held_r[2][5:2]};
    q_entry.b2    = {held_r[2][1:0], v};
    q_entry.mask  = {k2, k1, k0};
    q_entry.eol   = in_tlast;
    q_entry.count = c3;

    if (in_tlast) begin
      held_nxt[0] = 6'd0;
      held_nxt[1] = 6'd0;
      held_nxt[2] = 6'd0;
      inv_nxt     = 3'b000;
      pos_nxt     = 2'd0;
      halted_nxt  = 1'b0;
      cnt_nxt     = 16'd0;
    end
  end

  assign q_push = accept && (k0 || k1 || k2 || in_tlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r[0] <= 6'd0;
      held_r[1] <= 6'd0;
      held_r[2] <= 6'd0;
      inv_r     <= 3'b000;
      pos_r     <= 2'd0;
      halted_r  <= 1'b0;
      cnt_r     <= 16'd0;
      max_r     <= MAX_BYTES_RST;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (accept) begin
        held_r   <= held_nxt;
        inv_r    <= inv_nxt;
        pos_r    <= pos_nxt;
        halted_r <= halted_nxt;
        cnt_r    <= cnt_nxt;
      end
    end
  end

endmodule

// File: sv/b64_queue.sv
// Short queue of result entries between the front and the back.
module b64_queue import b64_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
      if (pop)  rd_r <= (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

// File: sv/b64_back.sv
// Back part: unpacks entries into single results behind an output register.
module b64_back import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  entry_t      q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  entry_t      cur_r, cur_nxt;
  logic        ov_r, ov_nxt;
  logic [23:0] od_r, od_nxt;
  logic        ou_r, ou_nxt;
  logic        ol_r, ol_nxt;
  logic        advance, busy;

  assign busy    = (cur_r.mask != 3'b000) || cur_r.eol;
  assign advance = !ov_r || out_tready;

  always_comb begin
    cur_nxt = cur_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    ou_nxt  = ou_r;
    ol_nxt  = ol_r;
    q_pop   = 1'b0;
    if (advance) begin
      ov_nxt = busy;
      if (cur_r.mask[0]) begin
        od_nxt          = {16'd0, cur_r.b0};
        ou_nxt          = KIND_BYTE;
        cur_nxt.mask[0] = 1'b0;
      end else if (cur_r.mask[1]) begin
        od_nxt          = {16'd0, cur_r.b1};
        ou_nxt          = KIND_BYTE;
        cur_nxt.mask[1] = 1'b0;
      end else if (cur_r.mask[2]) begin
        od_nxt          = {16'd0, cur_r.b2};
        ou_nxt          = KIND_BYTE;
        cur_nxt.mask[2] = 1'b0;
      end else begin
        od_nxt      = {cur_r.count, 8'd0};
        ou_nxt      = KIND_REPORT;
        cur_nxt.eol = 1'b0;
      end
      ol_nxt = (cur_nxt.mask == 3'b000) && !cur_nxt.eol;
    end
    // Refill once spent, so results flow every cycle unless out_tready stalls.
    if ((cur_nxt.mask == 3'b000) && !cur_nxt.eol && q_not_empty) begin
      q_pop   = 1'b1;
      cur_nxt = q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r       <= 1'b0;
      cur_r.mask <= 3'b000;
      cur_r.eol  <= 1'b0;
    end else begin
      ov_r  <= ov_nxt;
      cur_r <= cur_nxt;
    end
    od_r <= od_nxt;
    ou_r <= ou_nxt;
    ol_r <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REPORT) |-> out_tlast)
    else $error("count report not marked last");
  a_report_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REPORT) |-> out_tdata[7:0] == 8'd0)
    else $error("count report carries a data byte");
  a_byte_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_BYTE) |-> out_tdata[23:8] == 16'd0)
    else $error("decoded byte carries a count");

endmodule

// File: sv/base64_line_decoder.sv
// Top level of the base64 line decoder: front, queue and back.
//
//  channel | direction | tdata                         | tuser | tlast
//  --------+-----------+-------------------------------+-------+-------------
//  in_     | slave     | [7:0] char_code               | -     | end_of_line
//  out_    | master    | [7:0] data_byte,              | kind  | last_of_run
//          |           | [23:8] byte_count             |       |
//  cfg_    | write     | cfg_wdata[15:0] max_bytes     | -     | -
//
// A character is taken on a handshake; the front decodes it and, when it
// causes any results, writes one entry into a four-deep queue.
// The back emits one result per cycle from the queue unless out_tready holds,
// and a character causes zero to four results, while a full quad of
// four characters never causes more than four results.
// Input ready drops only when the queue is full; the output register lets
// a new character be taken while a result waits for out_tready.
// Reset is synchronous and active low; max_bytes returns to 6200.
module base64_line_decoder import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // max_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  input  logic        in_tlast,    // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] data_byte, [23:8] byte_count
  output logic        out_tuser,   // kind
  output logic        out_tlast    // last_of_run
);

  logic   q_push, q_full, q_pop, q_not_empty;
  entry_t q_in, q_head;

  // The front classifies each character transfer and tracks the line.
  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // The queue decouples a stalled output from the input side.
  b64_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // The back turns each entry into its byte and report transfers.
  b64_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
